FILE: hw/rtl/kts_pkg.sv
// Package with the shared types and constants of the key/tag sort engine.
`timescale 1ns / 1ps

package kts_pkg;

    // Fixed field widths.
    localparam int KEY_W = 64;
    localparam int TAG_W = 10;

    // Default values of the top-level parameters.
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_BYTES_DEF = 8;

    // One incoming record.
    typedef struct packed {
        logic [KEY_W-1:0] sort_key;
        logic [TAG_W-1:0] payload_tag;
        logic             final_item;
    } t_in_item;

    // One sorted result.
    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [TAG_W-1:0] out_tag;
        logic             out_last;
        logic             status;
    } t_out_item;

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

endpackage

FILE: hw/rtl/key_tag_sort_engine.sv
// Key/tag sort engine: records are inserted in key order as they load, then emitted in order.
// Loading a record scans down from the top of the store, moving each stored record with a larger
// key up one place; the single compare unit checks and shifts one stored entry per cycle.
// A new record is accepted only while idle, once the last insertion or read-out is done; each
// result is read through the registered read port of the record store and held while stalled.
// Reset (synchronous, active low) empties the store and clears the overflow flag and the output valid.
`timescale 1ns / 1ps

module key_tag_sort_engine
    import kts_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FETCH = 5'b00100,
        S_CATCH = 5'b01000,
        S_SHOW  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [ADDR_W-1:0]   r_oidx, n_oidx;
    t_rec                r_new, n_new;
    logic                r_final, n_final;
    logic                r_ovalid, n_ovalid;
    t_out_item           r_out, n_out;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    t_rec                wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    t_rec                rd_data;

    logic                in_xfer;
    logic                full;
    logic                key_gt;
    logic                at_last;

    assign in_xfer = i_valid && (r_state == S_IDLE);
    assign full    = (r_count == CNT_W'(CAPACITY));
    // The shared compare unit: stored key against the record being inserted.
    assign key_gt  = (rd_data.key > r_new.key);
    assign at_last = ((CNT_W'(r_oidx) + CNT_W'(1)) == r_count);

    kts_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer: insertion on load, then an ordered read-out on the final record.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_pos    = r_pos;
        n_oidx   = r_oidx;
        n_new    = r_new;
        n_final  = r_final;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_new;
        rd_en    = 1'b0;
        rd_addr  = r_pos - ADDR_W'(2);

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_new.key = i_item.sort_key & KEY_MASK;
                    n_new.tag = i_item.payload_tag;
                    n_final   = i_item.final_item;
                    n_oidx    = '0;
                    if (full) begin
                        n_ovf = 1'b1;
                        if (i_item.final_item) begin
                            n_state = S_FETCH;
                        end
                    end else begin
                        // Start the scan at the top of the store.
                        n_pos   = r_count[ADDR_W-1:0];
                        rd_en   = (r_count != '0);
                        rd_addr = ADDR_W'(r_count - CNT_W'(1));
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if ((r_pos != '0) && key_gt) begin
                    // Move the larger entry up one place and look at the next one down.
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    rd_en   = (r_pos >= ADDR_W'(2));
                    n_pos   = r_pos - ADDR_W'(1);
                end else begin
                    // Drop the new record into the gap; equal keys stay ahead of it.
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = r_final ? S_FETCH : S_IDLE;
                end
            end
            S_FETCH: begin
                rd_en   = 1'b1;
                rd_addr = r_oidx;
                n_state = S_CATCH;
            end
            S_CATCH: begin
                n_out.out_key  = rd_data.key;
                n_out.out_tag  = rd_data.tag;
                n_out.out_last = at_last;
                n_out.status   = r_ovf;
                n_ovalid       = 1'b1;
                n_state        = S_SHOW;
            end
            S_SHOW: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    if (r_out.out_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_oidx  = r_oidx + ADDR_W'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_oidx  <= n_oidx;
        r_new   <= n_new;
        r_final <= n_final;
        r_out   <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

endmodule

FILE: hw/rtl/kts_ram.sv
// Record store: one write port and one registered read port.
`timescale 1ns / 1ps

module kts_ram
    import kts_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEF,
    parameter int ADDR_W = $clog2(CAPACITY_DEF)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_rec              i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_rec              o_rd_data
);

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: test/key_tag_sort_engine_tb.sv
// Self-checking testbench for the key/tag sort engine: loads record sets and checks each sorted run.
`timescale 1ns / 1ps

module key_tag_sort_engine_tb;
    import kts_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int KEY_BYTES   = KEY_BYTES_DEF;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam int RECORD_TARGET = 210;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 150;

    // Keeps the records of the open set in sorted order and the results still owed.
    class sort_scoreboard;
        t_rec      set_q[$];
        bit        dropped;
        t_out_item owed_q[$];
        int        errors;
        int        records_in;
        int        results_checked;
        int        sets_closed;
        int        overflow_sets;

        // Notes one accepted input transfer; a final record releases the sorted run.
        function void note_input(t_in_item it);
            t_rec      rec;
            t_out_item res;
            int        pos;
            records_in++;
            if (set_q.size() < CAPACITY) begin
                rec.key = it.sort_key & KEY_MASK;
                rec.tag = it.payload_tag;
                // Insert after every stored key that is not larger, so ties keep load order.
                pos = set_q.size();
                while (pos > 0 && set_q[pos-1].key > rec.key) pos--;
                set_q.insert(pos, rec);
            end else begin
                dropped = 1'b1;
            end
            if (it.final_item) begin
                foreach (set_q[k]) begin
                    res.out_key  = set_q[k].key;
                    res.out_tag  = set_q[k].tag;
                    res.out_last = (k == set_q.size() - 1);
                    res.status   = dropped;
                    owed_q.push_back(res);
                end
                sets_closed++;
                if (dropped) overflow_sets++;
                set_q.delete();
                dropped = 1'b0;
            end
        endfunction

        function void field_check(string name, logic [KEY_W-1:0] exp, logic [KEY_W-1:0] act);
            if (act !== exp) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
                errors++;
            end
        endfunction

        // Checks one accepted output transfer against the oldest owed result.
        function void check_result(t_out_item got);
            t_out_item exp;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got key %h tag %h last %b status %b",
                         $time, got.out_key, got.out_tag, got.out_last, got.status);
                errors++;
                return;
            end
            exp = owed_q.pop_front();
            results_checked++;
            field_check("out_key", exp.out_key, got.out_key);
            field_check("out_tag", 64'(exp.out_tag), 64'(got.out_tag));
            field_check("out_last", 64'(exp.out_last), 64'(got.out_last));
            field_check("status", 64'(exp.status), 64'(got.status));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    sort_scoreboard sb = new();
    bit hold_armed;
    int idle_cycles;

    key_tag_sort_engine #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random keys: full-width values, a small pool that forces ties, and padded text.
    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] key;
        int len;
        case ($urandom_range(0, 2))
            0: key = {$urandom, $urandom};
            1: key = (64'($urandom_range(0, 3)) << 62) | 64'($urandom_range(0, 1));
            default: begin
                key = '0;
                len = $urandom_range(1, 8);
                for (int b = 0; b < len; b++) begin
                    key[KEY_W-1-8*b -: 8] = 8'($urandom_range(8'h20, 8'h7e));
                end
            end
        endcase
        return key;
    endfunction

    // Offers one record and waits for its input transfer.
    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input bit fin, input bit nogap);
        t_in_item it;
        int gap;
        it.sort_key    = key;
        it.payload_tag = tag;
        it.final_item  = fin;
        gap = nogap ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic send_random_set(input int size, input bit nogap);
        for (int k = 0; k < size; k++) begin
            send_record(rand_key(), TAG_W'($urandom_range(0, 1023)), k == size - 1, nogap);
        end
    endtask

    // Output side: random stalls, quiet stretches, and one long hold-off on request.
    initial begin : receiver
        int n;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && o_valid) begin
                hold_armed = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 149) == 0) begin
                i_stall <= 1'b0;
                repeat (80) @(posedge i_clk);
            end else begin
                n = gap_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    // Every output transfer is checked as it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence: reset, directed sets, random sets, drain.
    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        hold_armed  = 1'b0;
        idle_cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-record sets at both key and tag extremes.
        send_record(64'h0, 10'h000, 1'b1, 1'b0);
        send_record({KEY_W{1'b1}}, 10'h3FF, 1'b1, 1'b0);

        // Mixed set with extremes, a text prefix relation and ties in load order.
        send_record({KEY_W{1'b1}}, 10'h155, 1'b0, 1'b1);
        send_record(64'h4100_0000_0000_0000, 10'h001, 1'b0, 1'b1);
        send_record(64'h0, 10'h2AA, 1'b0, 1'b1);
        send_record(64'h4142_0000_0000_0000, 10'h3FF, 1'b0, 1'b0);
        send_record(64'h8000_0000_0000_0000, 10'h000, 1'b0, 1'b0);
        send_record(64'h4100_0000_0000_0000, 10'h002, 1'b1, 1'b0);

        // All keys equal: output must follow load order.
        send_record(64'h5A5A_5A5A_5A5A_5A5A, 10'h3FF, 1'b0, 1'b0);
        send_record(64'h5A5A_5A5A_5A5A_5A5A, 10'h000, 1'b0, 1'b0);
        send_record(64'h5A5A_5A5A_5A5A_5A5A, 10'h1C3, 1'b1, 1'b0);

        // Already ascending, then strictly descending.
        send_record(64'h1, 10'h010, 1'b0, 1'b0);
        send_record(64'h2, 10'h020, 1'b0, 1'b0);
        send_record(64'h3, 10'h030, 1'b1, 1'b0);
        send_record(64'hFFFF_0000_0000_0000, 10'h040, 1'b0, 1'b0);
        send_record(64'h00FF_0000_0000_0000, 10'h050, 1'b0, 1'b0);
        send_record(64'h0000_0000_0000_00FF, 10'h060, 1'b1, 1'b0);

        // A set that fills the store exactly, sent back to back.
        send_random_set(CAPACITY, 1'b1);

        // Over capacity: the last non-final record and the final one are both dropped.
        // The output side is held off meanwhile so the block backs up its input.
        hold_armed = 1'b1;
        send_random_set(CAPACITY + 2, 1'b0);

        // Small sets with random content until the record budget is used.
        while (sb.records_in < RECORD_TARGET) begin
            send_random_set($urandom_range(1, 8), $urandom_range(0, 3) == 0);
        end
        i_valid <= 1'b0;

        // Drain the owed results, then give the block time to show any stray transfer.
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.owed_q.size() != 0 || sb.set_q.size() != 0) begin
            $display("%0t: %0d results still owed at the end", $time, sb.owed_q.size());
            sb.errors++;
        end

        $display("Loaded %0d records in %0d sets, %0d of them over capacity.",
                 sb.records_in, sb.sets_closed, sb.overflow_sets);
        $display("Checked %0d sorted results, %0d mismatches.", sb.results_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
